// ----- sv/pdat_pkg.sv -----
// Shared types and constants of the P/D gain autotuner.
`timescale 1ns / 1ps

package pdat_pkg;

  // Thresholds in Q11.4 units.
  localparam logic [16:0] RATE_FLOOR  = 17'd16;   // 1.0 deg/s
  localparam logic [16:0] ANGLE_LIMIT = 17'd64;   // 4.0 deg

  // Configuration register indexes.
  localparam logic [2:0] REG_P_INIT_ROLL  = 3'd0;
  localparam logic [2:0] REG_P_INIT_PITCH = 3'd1;
  localparam logic [2:0] REG_D_INIT_ROLL  = 3'd2;
  localparam logic [2:0] REG_D_INIT_PITCH = 3'd3;
  localparam logic [2:0] REG_COOLDOWN     = 3'd4;
  localparam logic [2:0] REG_DEBOUNCE     = 3'd5;
  localparam logic [2:0] REG_TUNED_AFTER  = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [7:0]  RST_P_INIT      = 8'd20;
  localparam logic [7:0]  RST_D_INIT      = 8'd0;
  localparam logic [15:0] RST_COOLDOWN    = 16'd1000;
  localparam logic [15:0] RST_DEBOUNCE    = 16'd500;
  localparam logic [19:0] RST_TUNED_AFTER = 20'd30000;

  typedef struct packed {
    logic               axis;
    logic [31:0]        now_ms;
    logic signed [15:0] cmd_rate;
    logic signed [15:0] meas_rate;
    logic signed [15:0] setpoint;
    logic signed [15:0] meas_angle;
  } item_t;

  typedef struct packed {
    logic [7:0]  p_gain;
    logic [7:0]  d_gain;
    logic [31:0] err_start;
    logic        err_timing;
    logic [31:0] last_upd;
    logic        upd_once;
  } axis_state_t;

  typedef struct packed {
    logic [15:0] cooldown_ms;
    logic [15:0] debounce_ms;
    logic [19:0] tuned_after_ms;
  } tune_cfg_t;

  typedef struct packed {
    axis_state_t ax_next;
    logic        p_up;
    logic        d_up;
    logic        event_hit;
    logic        done_next;
  } eval_t;

  // Result packed with p_gain in the low bits.
  typedef struct packed {
    logic       tuned;
    logic       d_raised;
    logic       p_raised;
    logic [7:0] d_gain;
    logic [7:0] p_gain;
  } result_t;

  function automatic logic [16:0] mag17(input logic signed [16:0] v);
    logic [16:0] r;
    r = v[16] ? 17'(-v) : 17'(v);
    return r;
  endfunction

endpackage

// ----- sv/pdat_eval.sv -----
// Per-item tuning decision: thresholds, debounce, cooldown and gain steps.
`timescale 1ns / 1ps

module pdat_eval #(
  parameter int P_STEP_UNITS = 5,
  parameter int P_MAX_UNITS  = 120,
  parameter int D_STEP_UNITS = 2,
  parameter int D_MAX_UNITS  = 240
) (
  input  pdat_pkg::item_t       item,
  input  pdat_pkg::axis_state_t ax_st,
  input  pdat_pkg::tune_cfg_t   cfg,
  input  logic [31:0]           last_event,
  input  logic                  done,
  output pdat_pkg::eval_t       res
);
  import pdat_pkg::*;

  localparam logic [8:0] P_STEP = 9'(P_STEP_UNITS);
  localparam logic [8:0] P_MAX  = 9'(P_MAX_UNITS);
  localparam logic [8:0] D_STEP = 9'(D_STEP_UNITS);
  localparam logic [8:0] D_MAX  = 9'(D_MAX_UNITS);

  logic [16:0] areq, err, aset, aang;
  logic [21:0] err20, areq3;
  logic        cooling, active, big_err, deb_hit, d_cond;
  logic [31:0] start_eff;
  logic [8:0]  np, nd;
  logic        np_ok, nd_ok;

  always_comb begin
    areq  = mag17(17'(item.cmd_rate));
    err   = mag17(17'(item.cmd_rate) - 17'(item.meas_rate));
    aset  = mag17(17'(item.setpoint));
    aang  = mag17(17'(item.meas_angle) - 17'(item.setpoint));
    err20 = ({5'b0, err} << 4) + ({5'b0, err} << 2);
    areq3 = ({5'b0, areq} << 1) + {5'b0, areq};

    cooling = ax_st.upd_once &&
              ((item.now_ms - ax_st.last_upd) < {16'b0, cfg.cooldown_ms});
    active  = !done && (areq > RATE_FLOOR) && !cooling;
    big_err = (err > RATE_FLOOR) && (err20 > areq3);

    // debounce starts now if not already running
    start_eff = ax_st.err_timing ? ax_st.err_start : item.now_ms;
    deb_hit   = (item.now_ms - start_eff) > {16'b0, cfg.debounce_ms};
    d_cond    = !((aset < RATE_FLOOR) && (areq < RATE_FLOOR)) && (aang > ANGLE_LIMIT);

    np    = {1'b0, ax_st.p_gain} + P_STEP;
    nd    = {1'b0, ax_st.d_gain} + D_STEP;
    np_ok = np <= P_MAX;
    nd_ok = nd <= D_MAX;

    res         = '0;
    res.ax_next = ax_st;
    if (active && big_err) begin
      res.ax_next.err_timing = !deb_hit;
      res.ax_next.err_start  = start_eff;
      res.p_up               = deb_hit && np_ok;
    end else if (active) begin
      res.ax_next.err_timing = 1'b0;
      res.d_up               = d_cond && nd_ok;
    end

    res.event_hit = res.p_up || res.d_up;
    if (res.p_up) begin
      res.ax_next.p_gain = np[7:0];
    end
    if (res.d_up) begin
      res.ax_next.d_gain = nd[7:0];
    end
    if (res.event_hit) begin
      res.ax_next.last_upd = item.now_ms;
      res.ax_next.upd_once = 1'b1;
    end

    // an event this item resets the quiet time to zero
    res.done_next = done || (!res.event_hit &&
                    ((item.now_ms - last_event) > {12'b0, cfg.tuned_after_ms}));
  end

endmodule

// ----- sv/pd_gain_autotuner.sv -----
// Top level of the two-axis P/D gain autotuner.
`timescale 1ns / 1ps

// Two-axis P/D gain autotuner. Each request on s_* carries one axis sample
// (axis in s_tuser; time, rates and angles in s_tdata) and yields exactly one
// result on m_*: the axis gains after the sample, raise flags and the tuned
// flag. Throughput is one request per clock while m_tready keeps the result
// register draining; a request accepted at one edge is latched in the input
// register, then evaluated and written to the result register at the next
// edge where that register is free or being drained, which raises m_tvalid.
// The per-axis state read-modify-write is done in the same cycle as the
// decision, so a following sample on the same axis sees it.
// Configuration writes (cfg_valid/cfg_ready, always ready) are expected
// only while no request is in flight; writing an initial gain also reloads
// that axis's gain at once. Indexes beyond the register list are ignored.
module pd_gain_autotuner #(
  parameter int P_STEP_UNITS = 5,
  parameter int P_MAX_UNITS  = 120,
  parameter int D_STEP_UNITS = 2,
  parameter int D_MAX_UNITS  = 240
) (
  input  logic        clk,
  input  logic        rst,
  // input samples
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // now_ms[31:0], cmd_rate, meas_rate, setpoint, meas_angle
  input  logic        s_tuser,   // axis (0 roll, 1 pitch)
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // p_gain, d_gain, p_raised, d_raised, tuned, zero pad
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import pdat_pkg::*;

  // config registers
  tune_cfg_t  cfg;

  // per-axis state
  logic [7:0]  p_gain_q     [2];
  logic [7:0]  d_gain_q     [2];
  logic [31:0] err_start_q  [2];
  logic        err_timing_q [2];
  logic [31:0] last_upd_q   [2];
  logic        upd_once_q   [2];
  logic [31:0] last_event;
  logic        done;

  // pipeline registers
  logic        in_vld;
  item_t       in_q;
  logic        out_vld;
  result_t     out_q;
  logic        advance;

  axis_state_t ax_st;
  eval_t       ev;

  assign cfg_ready = 1'b1;
  assign advance   = in_vld && (!out_vld || m_tready);
  assign s_tready  = !in_vld || advance;
  assign m_tvalid  = out_vld;
  assign m_tdata   = {5'b0, out_q};

  always_comb begin
    ax_st.p_gain     = p_gain_q[in_q.axis];
    ax_st.d_gain     = d_gain_q[in_q.axis];
    ax_st.err_start  = err_start_q[in_q.axis];
    ax_st.err_timing = err_timing_q[in_q.axis];
    ax_st.last_upd   = last_upd_q[in_q.axis];
    ax_st.upd_once   = upd_once_q[in_q.axis];
  end

  pdat_eval #(
    .P_STEP_UNITS(P_STEP_UNITS),
    .P_MAX_UNITS (P_MAX_UNITS),
    .D_STEP_UNITS(D_STEP_UNITS),
    .D_MAX_UNITS (D_MAX_UNITS)
  ) u_eval (
    .item      (in_q),
    .ax_st     (ax_st),
    .cfg       (cfg),
    .last_event(last_event),
    .done      (done),
    .res       (ev)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_q.axis       <= s_tuser;
      in_q.now_ms     <= s_tdata[31:0];
      in_q.cmd_rate   <= s_tdata[47:32];
      in_q.meas_rate  <= s_tdata[63:48];
      in_q.setpoint   <= s_tdata[79:64];
      in_q.meas_angle <= s_tdata[95:80];
    end
    if (advance) begin
      out_q.p_gain   <= ev.ax_next.p_gain;
      out_q.d_gain   <= ev.ax_next.d_gain;
      out_q.p_raised <= ev.p_up;
      out_q.d_raised <= ev.d_up;
      out_q.tuned    <= ev.done_next;
    end
  end

  // control, config and tuning state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld             <= 1'b0;
      out_vld            <= 1'b0;
      cfg.cooldown_ms    <= RST_COOLDOWN;
      cfg.debounce_ms    <= RST_DEBOUNCE;
      cfg.tuned_after_ms <= RST_TUNED_AFTER;
      for (int i = 0; i < 2; i++) begin
        p_gain_q[i]     <= RST_P_INIT;
        d_gain_q[i]     <= RST_D_INIT;
        err_start_q[i]  <= '0;
        err_timing_q[i] <= 1'b0;
        last_upd_q[i]   <= '0;
        upd_once_q[i]   <= 1'b0;
      end
      last_event <= '0;
      done       <= 1'b0;
    end else begin
      if (s_tready) begin
        in_vld <= s_tvalid;
      end
      if (advance) begin
        out_vld <= 1'b1;
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end

      if (advance) begin
        p_gain_q[in_q.axis]     <= ev.ax_next.p_gain;
        d_gain_q[in_q.axis]     <= ev.ax_next.d_gain;
        err_start_q[in_q.axis]  <= ev.ax_next.err_start;
        err_timing_q[in_q.axis] <= ev.ax_next.err_timing;
        last_upd_q[in_q.axis]   <= ev.ax_next.last_upd;
        upd_once_q[in_q.axis]   <= ev.ax_next.upd_once;
        if (ev.event_hit) begin
          last_event <= in_q.now_ms;
        end
        done <= ev.done_next;
      end

      // gain init writes load the live gain of that axis
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_P_INIT_ROLL: begin
            p_gain_q[0] <= cfg_data[7:0];
          end
          REG_P_INIT_PITCH: begin
            p_gain_q[1] <= cfg_data[7:0];
          end
          REG_D_INIT_ROLL: begin
            d_gain_q[0] <= cfg_data[7:0];
          end
          REG_D_INIT_PITCH: begin
            d_gain_q[1] <= cfg_data[7:0];
          end
          REG_COOLDOWN:    cfg.cooldown_ms    <= cfg_data[15:0];
          REG_DEBOUNCE:    cfg.debounce_ms    <= cfg_data[15:0];
          REG_TUNED_AFTER: cfg.tuned_after_ms <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- sv/pdat_checker.sv -----
// Port-level checks of the autotuner, bound to the top level.
`timescale 1ns / 1ps

module pdat_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // held result must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one item raises at most one gain
  a_one_raise: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[16] && m_tdata[17]))
    else $error("P and D raised together");

  // a raise restarts the quiet time, so it cannot coincide with tuned
  a_no_raise_when_tuned: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |-> !(m_tdata[16] || m_tdata[17]))
    else $error("gain raised on a tuned result");

  // empty output stage never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind pd_gain_autotuner pdat_checker u_pdat_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the two-axis P/D gain autotuner.
`timescale 1ns / 1ps

module tb_top;
  import pdat_pkg::*;

  // Gain steps and ceilings; the block is built with its defaults.
  localparam int P_STEP = 5;
  localparam int P_MAX  = 120;
  localparam int D_STEP = 2;
  localparam int D_MAX  = 240;

  localparam int FLOOR = int'(RATE_FLOOR);   // 1.0 deg/s
  localparam int ANGLE = int'(ANGLE_LIMIT);  // 4.0 deg

  // Index past the register list; writes to it must be dropped.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // Cycles without any handshake before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;

  // Shadow of the block's state.
  typedef struct packed {
    logic [1:0][7:0]  p_gain;
    logic [1:0][7:0]  d_gain;
    logic [1:0][31:0] err_start;
    logic [1:0]       err_on;
    logic [1:0][31:0] upd_time;
    logic [1:0]       upd_valid;
    logic [31:0]      event_time;
    logic             done;
  } tuner_t;

  // One directed request; typed rows carry their own expectation.
  typedef struct packed {
    item_t   smp;
    logic    typed;
    result_t want;
  } script_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;   // now_ms[31:0], cmd_rate, meas_rate, setpoint, meas_angle
  logic        s_tuser;   // axis (0 roll, 1 pitch)
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // p_gain, d_gain, p_raised, d_raised, tuned, zero pad
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [19:0] cfg_data;

  tuner_t      tuner;          // predicted state after every accepted request
  tune_cfg_t   limits;         // predicted timing registers
  result_t     gain_reports[$]; // results still owed by the block
  logic [31:0] cursor;         // timestamp of the last request sent
  logic        last_axis;
  bit          steady;         // both sides run without stalls
  int          fail_count;
  int          quiet_cycles;

  pd_gain_autotuner dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gains and flags after one sample; nx is the state the sample leaves.
  function automatic result_t predict_gains(input item_t s, input tuner_t st,
                                            output tuner_t nx);
    int          req, act, sp, ang, areq, err, aset, aerr, np, nd;
    logic        ax, cooling;
    logic [31:0] now;
    result_t     r;
    nx  = st;
    r   = '0;
    ax  = s.axis;
    now = s.now_ms;
    req = s.cmd_rate;
    act = s.meas_rate;
    sp  = s.setpoint;
    ang = s.meas_angle;
    if (!st.done) begin
      areq = (req < 0) ? -req : req;
      // cooldown only counts once the axis has had an update
      cooling = st.upd_valid[ax] && ((now - st.upd_time[ax]) < 32'(limits.cooldown_ms));
      if (areq > FLOOR && !cooling) begin
        err = req - act;
        if (err < 0) err = -err;
        // err > max(1.0, 0.15 * |req|), done as 20*err > 3*|req|
        if (err > FLOOR && 20 * err > 3 * areq) begin
          if (!nx.err_on[ax]) begin
            nx.err_on[ax]    = 1'b1;
            nx.err_start[ax] = now;
          end
          if ((now - nx.err_start[ax]) > 32'(limits.debounce_ms)) begin
            np = int'(nx.p_gain[ax]) + P_STEP;
            nx.err_on[ax] = 1'b0;
            if (np <= P_MAX) begin
              nx.p_gain[ax]    = 8'(np);
              nx.upd_time[ax]  = now;
              nx.upd_valid[ax] = 1'b1;
              nx.event_time    = now;
              r.p_raised       = 1'b1;
            end
          end
        end else begin
          nx.err_on[ax] = 1'b0;
          aset = (sp < 0) ? -sp : sp;
          aerr = ang - sp;
          if (aerr < 0) aerr = -aerr;
          if (!(aset < FLOOR && areq < FLOOR) && aerr > ANGLE) begin
            nd = int'(nx.d_gain[ax]) + D_STEP;
            if (nd <= D_MAX) begin
              nx.d_gain[ax]    = 8'(nd);
              nx.upd_time[ax]  = now;
              nx.upd_valid[ax] = 1'b1;
              nx.event_time    = now;
              r.d_raised       = 1'b1;
            end
          end
        end
      end
      if ((now - nx.event_time) > 32'(limits.tuned_after_ms)) nx.done = 1'b1;
    end
    r.p_gain = nx.p_gain[ax];
    r.d_gain = nx.d_gain[ax];
    r.tuned  = nx.done;
    return r;
  endfunction

  function automatic item_t sample_of(input logic ax, input logic [31:0] t, input int rq,
                                      input int ac, input int sp, input int an);
    item_t s;
    s.axis       = ax;
    s.now_ms     = t;
    s.cmd_rate   = 16'(rq);
    s.meas_rate  = 16'(ac);
    s.setpoint   = 16'(sp);
    s.meas_angle = 16'(an);
    return s;
  endfunction

  function automatic result_t report_of(input int p, input int d, input logic pr,
                                        input logic dr, input logic tn);
    result_t r;
    r.p_gain   = 8'(p);
    r.d_gain   = 8'(d);
    r.p_raised = pr;
    r.d_raised = dr;
    r.tuned    = tn;
    return r;
  endfunction

  task automatic note_fail(input string what, input int unsigned want, input int unsigned got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %0s: expected %0d, got %0d", what, want, got);
  endtask

  // Register write; the shadow state follows the block's rules for each index.
  task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_P_INIT_ROLL:  tuner.p_gain[0] = data[7:0];
      REG_P_INIT_PITCH: tuner.p_gain[1] = data[7:0];
      REG_D_INIT_ROLL:  tuner.d_gain[0] = data[7:0];
      REG_D_INIT_PITCH: tuner.d_gain[1] = data[7:0];
      REG_COOLDOWN:     limits.cooldown_ms = data[15:0];
      REG_DEBOUNCE:     limits.debounce_ms = data[15:0];
      REG_TUNED_AFTER:  limits.tuned_after_ms = data[19:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [19:0] pr, input logic [19:0] pp,
                                input logic [19:0] dr, input logic [19:0] dp,
                                input logic [19:0] cool, input logic [19:0] deb,
                                input logic [19:0] quiet);
    write_reg(REG_P_INIT_ROLL, pr);
    write_reg(REG_P_INIT_PITCH, pp);
    write_reg(REG_D_INIT_ROLL, dr);
    write_reg(REG_D_INIT_PITCH, dp);
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_TUNED_AFTER, quiet);
    cfg_valid <= 1'b0;
  endtask

  // Send one sample, then log what it must produce.
  task automatic issue(input item_t s, input logic typed, input result_t want);
    tuner_t  nx;
    result_t r;
    while (!steady && $urandom_range(0, 99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= s.axis;
    s_tdata  <= {s.meas_angle, s.setpoint, s.meas_rate, s.cmd_rate, s.now_ms};
    do @(posedge clk); while (!s_tready);
    r     = predict_gains(s, tuner, nx);
    tuner = nx;
    gain_reports.push_back(typed ? want : r);
    cursor    = s.now_ms;
    last_axis = s.axis;
  endtask

  // Sender holds off until every owed result is in, plus pipeline slack.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (gain_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed flight samples aimed at the P and D paths, with noise.
  // Outside the closing phase a sample that would end tuning is pulled back
  // inside the quiet window, since tuning never clears short of reset.
  task automatic draw_sample(input bit closing, output item_t s);
    int      kind, mg, req, act, sp, ang, tsel;
    tuner_t  trial;
    result_t r;
    kind = $urandom_range(0, 99);
    tsel = $urandom_range(0, 99);
    mg   = $urandom_range(17, 3000);
    req  = $urandom_range(0, 1) ? mg : -mg;
    sp   = int'($urandom_range(0, 4000)) - 2000;
    if (tsel < 5) kind = 40;  // time jumps only stick when they raise D
    if (kind < 30) begin
      act = $urandom_range(0, 1) ? -req : req / 4;
      ang = sp + int'($urandom_range(0, 128)) - 64;
    end else if (kind < 55) begin
      act = req + int'($urandom_range(0, 16)) - 8;
      ang = sp + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(65, 600));
    end else if (kind < 75) begin
      act = req + int'($urandom_range(0, 16)) - 8;
      ang = sp + int'($urandom_range(0, 128)) - 64;
    end else begin
      req = int'($urandom_range(0, 65535));
      act = int'($urandom_range(0, 65535));
      sp  = int'($urandom_range(0, 65535));
      ang = int'($urandom_range(0, 65535));
    end
    s = sample_of(($urandom_range(0, 3) == 0) ? ~last_axis : last_axis, cursor,
                  req, act, sp, ang);
    if (tsel < 5 || (closing && tsel < 50)) s.now_ms = $urandom;
    else if (tsel < 8) s.now_ms = cursor - $urandom_range(1, 2000);
    else if (tsel < 18) s.now_ms = cursor + $urandom_range(0, 5000);
    else if (tsel < 28) s.now_ms = cursor;
    else s.now_ms = cursor + $urandom_range(1, 400);
    if (!closing) begin
      r = predict_gains(s, tuner, trial);
      if (r.tuned) s.now_ms = tuner.event_time + $urandom_range(0, limits.tuned_after_ms);
    end
  endtask

  task automatic run_phase(input int n, input bit closing, input int calm_lo,
                           input int calm_hi);
    item_t s;
    for (int i = 0; i < n; i++) begin
      steady = (i >= calm_lo && i < calm_hi);
      draw_sample(closing, s);
      issue(s, 1'b0, '0);
    end
    steady = 1'b0;
  endtask

  // Result side: random stalls, field-by-field compare against the oldest entry.
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[18:0];
      if (gain_reports.size() == 0) begin
        note_fail("unexpected result", 0, 32'(m_tdata));
      end else begin
        want = gain_reports.pop_front();
        if (got.p_gain != want.p_gain)
          note_fail("p_gain", 32'(want.p_gain), 32'(got.p_gain));
        if (got.d_gain != want.d_gain)
          note_fail("d_gain", 32'(want.d_gain), 32'(got.d_gain));
        if (got.p_raised != want.p_raised)
          note_fail("p_raised", 32'(want.p_raised), 32'(got.p_raised));
        if (got.d_raised != want.d_raised)
          note_fail("d_raised", 32'(want.d_raised), 32'(got.d_raised));
        if (got.tuned != want.tuned)
          note_fail("tuned", 32'(want.tuned), 32'(got.tuned));
        if (m_tdata[23:19] != '0) note_fail("pad bits", 0, 32'(m_tdata[23:19]));
      end
    end
    m_tready <= steady || ($urandom_range(0, 99) >= 18);
  end

  // Hang detector: any handshake resets the count.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[pd_gain_autotuner] ERROR");
        $finish;
      end
    end
  end

  initial begin
    script_row_t script[$];
    script_row_t row;

    rst          <= 1'b1;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tuser      <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_P_INIT_ROLL;
    cfg_data     <= '0;
    fail_count   = 0;
    steady       = 1'b0;
    cursor       = '0;
    last_axis    = 1'b0;

    // shadow state after reset
    tuner        = '0;
    tuner.p_gain = {RST_P_INIT, RST_P_INIT};
    tuner.d_gain = {RST_D_INIT, RST_D_INIT};
    limits.cooldown_ms    = RST_COOLDOWN;
    limits.debounce_ms    = RST_DEBOUNCE;
    limits.tuned_after_ms = RST_TUNED_AFTER;

    // Directed part, reset settings: cooldown 1000, debounce 500, quiet 30000.
    // after reset, nothing evaluated at zero rate
    script.push_back('{sample_of(0, 0, 0, 0, 0, 0), 1'b1, report_of(20, 0, 0, 0, 0)});
    // full-scale angle error raises D
    script.push_back('{sample_of(1, 10, 32767, 32767, -32768, 32767), 1'b1,
                       report_of(20, 2, 0, 1, 0)});
    // same again inside the cooldown: held
    script.push_back('{sample_of(1, 20, 32767, 32767, -32768, 32767), 1'b1,
                       report_of(20, 2, 0, 0, 0)});
    // full-scale rate error starts the debounce, fires 501 ms later
    script.push_back('{sample_of(0, 100, -32768, 32767, 0, 0), 1'b0, '0});
    script.push_back('{sample_of(0, 601, -32768, 32767, 0, 0), 1'b1,
                       report_of(25, 0, 1, 0, 0)});
    script.push_back('{sample_of(0, 700, -32768, 32767, 0, 0), 1'b0, '0});
    // |req| exactly 1.0: not evaluated
    script.push_back('{sample_of(0, 1601, 16, -32768, 0, 0), 1'b0, '0});
    // rate error just over the floor; debounce exactly at the limit, then past it
    script.push_back('{sample_of(0, 1602, 17, 0, 0, 0), 1'b0, '0});
    script.push_back('{sample_of(0, 2102, 17, 0, 0, 0), 1'b0, '0});
    script.push_back('{sample_of(0, 2103, 17, 0, 0, 0), 1'b0, '0});
    // error exactly 15 percent is small; angle just over 4.0 raises D
    script.push_back('{sample_of(1, 2200, 1000, 850, 0, 65), 1'b0, '0});
    script.push_back('{sample_of(1, 3300, 1000, 849, 0, 0), 1'b0, '0});
    // small error clears the debounce; angle exactly 4.0 does nothing
    script.push_back('{sample_of(1, 3400, 1000, 1000, 0, 64), 1'b0, '0});
    script.push_back('{sample_of(1, 3500, -17, -17, 15, -60), 1'b0, '0});
    // top of the time range, then cooldown across the wrap
    script.push_back('{sample_of(0, 32'hFFFF_FFFF, 1000, 1000, 0, -1000), 1'b0, '0});
    script.push_back('{sample_of(0, 16, 1000, 0, 0, 0), 1'b0, '0});
    script.push_back('{sample_of(0, 1500, 1000, 0, 0, 0), 1'b0, '0});
    script.push_back('{sample_of(1, 1600, 2000, 2000, 32767, -32768), 1'b0, '0});
    script.push_back('{sample_of(1, 1601, -2000, 0, -1, 0), 1'b0, '0});

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      row = script[i];
      issue(row.smp, row.typed, row.want);
    end
    drain();

    // gains just under the ceilings (P at 115 and 118, D at 236 and 239), no cooldown or debounce
    apply_settings(20'd115, 20'd118, 20'd236, 20'd239, 20'd0, 20'd0, 20'hFFFFF);
    run_phase(130, 1'b0, -1, -1);
    drain();

    // register extremes: gains at zero and at 255 (past the ceilings), longest timers
    apply_settings(20'd0, 20'd255, 20'd255, 20'd0, 20'd65535, 20'd65535, 20'hFFFFF);
    run_phase(130, 1'b0, -1, -1);
    drain();

    // random settings with junk in the upper data bits; stall-free stretch
    write_reg(REG_UNUSED, 20'($urandom));
    apply_settings(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                   20'($urandom_range(0, 3000)), 20'($urandom_range(0, 2000)),
                   20'($urandom_range(200000, 1048575)));
    run_phase(130, 1'b0, 30, 110);
    drain();

    // back to the reset values
    apply_settings(20'd20, 20'd20, 20'd0, 20'd0, 20'd1000, 20'd500, 20'd30000);
    run_phase(130, 1'b0, -1, -1);
    drain();

    // zero quiet time: tuning completes and freezes everything after
    apply_settings(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                   20'($urandom_range(0, 3000)), 20'($urandom_range(0, 3000)), 20'd0);
    run_phase(100, 1'b1, -1, -1);
    drain();

    repeat (16) @(posedge clk);
    if (gain_reports.size() != 0) note_fail("results missing", 0, gain_reports.size());
    if (fail_count == 0) begin
      $display("[pd_gain_autotuner] OK");
    end else begin
      $display("[pd_gain_autotuner] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/pdat_pkg.sv
sv/pdat_eval.sv
sv/pd_gain_autotuner.sv
sv/pdat_checker.sv
tb/tb_top.sv
